FILE: hw/rtl/sdfc_pkg.sv
package sdfc_pkg;

  // field widths
  localparam int POS_W    = 32;
  localparam int DIFF_W   = POS_W + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int SUM_W    = SQ_W;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int SH_W     = 2 * ROOT_W;
  localparam int SREM_W   = ROOT_W + 3;
  localparam int STIFF_W  = 16;
  localparam int DAMP_W   = 24;
  localparam int MAXE_W   = 31;
  localparam int ME2_W    = 2 * MAXE_W;
  localparam int NUM_W    = DIFF_W + MAXE_W;
  localparam int QUO_W    = MAXE_W;
  localparam int DREM_W   = ROOT_W + 1;
  localparam int PK_W     = STIFF_W + 1 + DIFF_W;
  localparam int PD_W     = DAMP_W + 1 + DIFF_W;
  localparam int FSUM_W   = PD_W + 1;
  localparam int FORCE_W  = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = MAXE_W;
  localparam int LANES    = 3;

  // pipeline depths
  localparam int SQRT_LAT = ROOT_W;
  localparam int DIV_LAT  = QUO_W;
  localparam int LINE_LEN = SQRT_LAT + 2;
  localparam int PIPE_LAT = 3 + SQRT_LAT + 1 + DIV_LAT + 2;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STIFFNESS = 2'd0,
    REG_DAMPING   = 2'd1,
    REG_MAX_EXT   = 2'd2
  } cfg_reg_t;

  localparam logic [STIFF_W-1:0] STIFF_RST = 16'd6400;
  localparam logic [DAMP_W-1:0]  DAMP_RST  = 24'd0;
  localparam logic [MAXE_W-1:0]  MAXE_RST  = 31'd12800;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic signed [FORCE_W-1:0] force_z;
    logic                      was_clamped;
  } result_t;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] v);
    abs_diff = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

endpackage

FILE: hw/rtl/sdfc_if.sv
interface sdfc_in_if;
  import sdfc_pkg::*;
  logic valid;
  logic ready;
  logic signed [POS_W-1:0] target_x;
  logic signed [POS_W-1:0] target_y;
  logic signed [POS_W-1:0] target_z;
  logic signed [POS_W-1:0] target_vel_x;
  logic signed [POS_W-1:0] target_vel_y;
  logic signed [POS_W-1:0] target_vel_z;
  logic signed [POS_W-1:0] body_x;
  logic signed [POS_W-1:0] body_y;
  logic signed [POS_W-1:0] body_z;
  logic signed [POS_W-1:0] body_vel_x;
  logic signed [POS_W-1:0] body_vel_y;
  logic signed [POS_W-1:0] body_vel_z;

  modport source (
    output valid, target_x, target_y, target_z, target_vel_x, target_vel_y, target_vel_z,
           body_x, body_y, body_z, body_vel_x, body_vel_y, body_vel_z,
    input  ready
  );
  modport sink (
    input  valid, target_x, target_y, target_z, target_vel_x, target_vel_y, target_vel_z,
           body_x, body_y, body_z, body_vel_x, body_vel_y, body_vel_z,
    output ready
  );
endinterface

interface sdfc_out_if;
  import sdfc_pkg::*;
  logic valid;
  logic ready;
  logic signed [FORCE_W-1:0] force_x;
  logic signed [FORCE_W-1:0] force_y;
  logic signed [FORCE_W-1:0] force_z;
  logic was_clamped;

  modport source (output valid, force_x, force_y, force_z, was_clamped, input ready);
  modport sink (input valid, force_x, force_y, force_z, was_clamped, output ready);
endinterface

FILE: hw/rtl/sdfc_sqrt.sv
module sdfc_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [sdfc_pkg::SUM_W-1:0]   s_in,
  output logic [sdfc_pkg::ROOT_W-1:0]  root_out
);
  import sdfc_pkg::*;

  logic [SREM_W-1:0] rem_r  [SQRT_LAT];
  logic [ROOT_W-1:0] root_r [SQRT_LAT];
  logic [SH_W-1:0]   sh_r   [SQRT_LAT];

  // one result bit per stage, two radicand bits consumed per stage
  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_step
    logic [SREM_W-1:0] rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [SH_W-1:0]   sh_p;
    logic [SREM_W-1:0] rem_t;
    logic [SREM_W-1:0] trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign sh_p   = SH_W'(s_in);
    end else begin : g_rest
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign sh_p   = sh_r[k-1];
    end

    assign rem_t = {rem_p[SREM_W-3:0], sh_p[SH_W-1 -: 2]};
    assign trial = SREM_W'({root_p, 2'b01});
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (rem_t - trial) : rem_t;
        root_r[k] <= {root_p[ROOT_W-2:0], ge};
        sh_r[k]   <= {sh_p[SH_W-3:0], 2'b00};
      end
    end
  end

  assign root_out = root_r[SQRT_LAT-1];

endmodule

FILE: hw/rtl/sdfc_lane.sv
module sdfc_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [sdfc_pkg::POS_W-1:0]   target,
  input  logic signed [sdfc_pkg::POS_W-1:0]   target_vel,
  input  logic signed [sdfc_pkg::POS_W-1:0]   body,
  input  logic signed [sdfc_pkg::POS_W-1:0]   body_vel,
  input  logic [sdfc_pkg::STIFF_W-1:0]        stiffness,
  input  logic [sdfc_pkg::DAMP_W-1:0]         damping_gain,
  input  logic [sdfc_pkg::MAXE_W-1:0]         max_extension,
  input  logic [sdfc_pkg::ROOT_W-1:0]         len_in,
  input  logic                                clamp_in,
  output logic [sdfc_pkg::SQ_W-1:0]           sq_out,
  output logic signed [sdfc_pkg::FORCE_W-1:0] force_out,
  output logic                                clamp_out
);
  import sdfc_pkg::*;

  logic signed [DIFF_W-1:0] dl1_r, dv1_r;
  logic [SQ_W-1:0]          sq2_r;
  logic signed [DIFF_W-1:0] dl_d_r [LINE_LEN];
  logic signed [DIFF_W-1:0] dv_d_r [LINE_LEN];
  logic [DIFF_W-1:0]        mag37;

  logic [NUM_W-1:0]         num_r;
  logic [ROOT_W-1:0]        len38_r;
  logic                     clamp38_r;
  logic signed [DIFF_W-1:0] dl38_r, dv38_r;

  logic [DREM_W-1:0]        drem_r  [DIV_LAT];
  logic [QUO_W-1:0]         dq_r    [DIV_LAT];
  logic [QUO_W-1:0]         dlow_r  [DIV_LAT];
  logic [ROOT_W-1:0]        dlen_r  [DIV_LAT];
  logic                     dclamp_r[DIV_LAT];
  logic signed [DIFF_W-1:0] ddl_r   [DIV_LAT];
  logic signed [DIFF_W-1:0] ddv_r   [DIV_LAT];

  logic signed [DIFF_W-1:0] q_s, dl_fin;
  logic signed [PK_W-1:0]   pk_r;
  logic signed [PD_W-1:0]   pd_r;
  logic                     clamp70_r;
  logic signed [FSUM_W-1:0] fsum;
  logic signed [FORCE_W-1:0] force_r;
  logic                     clamp71_r;

  // differences, then squared magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      dl1_r <= DIFF_W'(target) - DIFF_W'(body);
      dv1_r <= DIFF_W'(target_vel) - DIFF_W'(body_vel);
      sq2_r <= abs_diff(dl1_r) * abs_diff(dl1_r);
    end
  end
  assign sq_out = sq2_r;

  // hold the errors while the length is found
  always_ff @(posedge clk) begin
    if (en) begin
      dl_d_r[0] <= dl1_r;
      dv_d_r[0] <= dv1_r;
      for (int i = 1; i < LINE_LEN; i++) begin
        dl_d_r[i] <= dl_d_r[i-1];
        dv_d_r[i] <= dv_d_r[i-1];
      end
    end
  end
  assign mag37 = abs_diff(dl_d_r[LINE_LEN-1]);

  // dividend |dl| * limit
  always_ff @(posedge clk) begin
    if (en) begin
      num_r     <= NUM_W'(mag37) * NUM_W'(max_extension);
      len38_r   <= len_in;
      clamp38_r <= clamp_in;
      dl38_r    <= dl_d_r[LINE_LEN-1];
      dv38_r    <= dv_d_r[LINE_LEN-1];
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < DIV_LAT; j++) begin : g_div
    logic [DREM_W-1:0]        rem_p;
    logic [QUO_W-1:0]         q_p, low_p;
    logic [ROOT_W-1:0]        d_p;
    logic                     c_p;
    logic signed [DIFF_W-1:0] dl_p, dv_p;
    logic [DREM_W-1:0]        rem_t, dd;
    logic                     ge;

    if (j == 0) begin : g_first
      assign rem_p = DREM_W'(num_r[NUM_W-1:QUO_W]);
      assign q_p   = '0;
      assign low_p = num_r[QUO_W-1:0];
      assign d_p   = len38_r;
      assign c_p   = clamp38_r;
      assign dl_p  = dl38_r;
      assign dv_p  = dv38_r;
    end else begin : g_rest
      assign rem_p = drem_r[j-1];
      assign q_p   = dq_r[j-1];
      assign low_p = dlow_r[j-1];
      assign d_p   = dlen_r[j-1];
      assign c_p   = dclamp_r[j-1];
      assign dl_p  = ddl_r[j-1];
      assign dv_p  = ddv_r[j-1];
    end

    assign rem_t = {rem_p[DREM_W-2:0], low_p[QUO_W-1]};
    assign dd    = DREM_W'(d_p);
    assign ge    = rem_t >= dd;

    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[j]   <= ge ? (rem_t - dd) : rem_t;
        dq_r[j]     <= {q_p[QUO_W-2:0], ge};
        dlow_r[j]   <= {low_p[QUO_W-2:0], 1'b0};
        dlen_r[j]   <= d_p;
        dclamp_r[j] <= c_p;
        ddl_r[j]    <= dl_p;
        ddv_r[j]    <= dv_p;
      end
    end
  end

  // pick the error, then spring and damper products
  assign q_s    = $signed(DIFF_W'(dq_r[DIV_LAT-1]));
  assign dl_fin = dclamp_r[DIV_LAT-1]
                ? (ddl_r[DIV_LAT-1][DIFF_W-1] ? -q_s : q_s)
                : ddl_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      pk_r      <= PK_W'($signed({1'b0, stiffness})) * PK_W'(dl_fin);
      pd_r      <= PD_W'($signed({1'b0, damping_gain})) * PD_W'(ddv_r[DIV_LAT-1]);
      clamp70_r <= dclamp_r[DIV_LAT-1];
    end
  end

  // sum and saturate
  assign fsum = FSUM_W'(pk_r) + FSUM_W'(pd_r);

  always_ff @(posedge clk) begin
    if (en) begin
      if (fsum[FSUM_W-1:FORCE_W-1] == '0 || fsum[FSUM_W-1:FORCE_W-1] == '1) begin
        force_r <= fsum[FORCE_W-1:0];
      end else if (fsum[FSUM_W-1]) begin
        force_r <= {1'b1, {(FORCE_W-1){1'b0}}};
      end else begin
        force_r <= {1'b0, {(FORCE_W-1){1'b1}}};
      end
      clamp71_r <= clamp70_r;
    end
  end

  assign force_out = force_r;
  assign clamp_out = clamp71_r;

endmodule

FILE: hw/rtl/spring_damper_force_with_clamp.sv
// Spring-damper force with length clamp.
// Input channel in_if: one beat carries target position and velocity and body
// position and velocity, all signed Q24.8. Output channel out_if: one beat
// carries the saturated 48-bit force per axis and a flag set when the position
// error was cut back to max_extension.
// Three axis lanes compute the errors; a merge stage sums the squared
// position error, a 33-stage square root finds its length and each lane runs a
// 31-stage divider to rescale its error, then forms stiffness * dL + damping * dV.
// Throughput: one beat per cycle while the pipeline is not stalled.
// A two-entry output queue sits after the pipeline, so new beats are taken
// while a finished result waits; the pipeline stalls as a whole only once the
// queue is full and the receiver holds ready low.
// Reset (rst_n low, synchronous) empties the pipeline and the queue and loads
// stiffness 25.0, damping 0 and max_extension 50.0. The cfg port is written by
// index; writes to an unused index are dropped.
module spring_damper_force_with_clamp (
  input  logic                                clk,
  input  logic                                rst_n,
  sdfc_in_if.sink                             in_if,
  sdfc_out_if.source                          out_if,
  input  logic                                cfg_we,
  input  logic [sdfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdfc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sdfc_pkg::*;

  logic [STIFF_W-1:0] stiffness_r;
  logic [DAMP_W-1:0]  damping_r;
  logic [MAXE_W-1:0]  maxe_r;
  logic [ME2_W-1:0]   me2_r;

  logic               en;
  logic [PIPE_LAT-1:0] v_r;

  logic signed [POS_W-1:0] tgt [LANES];
  logic signed [POS_W-1:0] tvl [LANES];
  logic signed [POS_W-1:0] bdy [LANES];
  logic signed [POS_W-1:0] bvl [LANES];
  logic [SQ_W-1:0]         sq  [LANES];
  logic signed [FORCE_W-1:0] frc [LANES];
  logic                    lclamp [LANES];

  logic [SUM_W-1:0]  s_r;
  logic              clamp3_r;
  logic              clamp_d_r [SQRT_LAT];
  logic [ROOT_W-1:0] root;

  result_t           q_r [2];
  result_t           res;
  logic              wptr_r, rptr_r;
  logic [1:0]        cnt_r;
  logic              push, pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiffness_r <= STIFF_RST;
      damping_r   <= DAMP_RST;
      maxe_r      <= MAXE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STIFFNESS: stiffness_r <= cfg_data[STIFF_W-1:0];
        REG_DAMPING:   damping_r   <= cfg_data[DAMP_W-1:0];
        REG_MAX_EXT:   maxe_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // squared limit, follows the register
  always_ff @(posedge clk) begin
    me2_r <= ME2_W'(maxe_r) * ME2_W'(maxe_r);
  end

  assign tgt[0] = in_if.target_x;     assign tgt[1] = in_if.target_y;
  assign tgt[2] = in_if.target_z;
  assign tvl[0] = in_if.target_vel_x; assign tvl[1] = in_if.target_vel_y;
  assign tvl[2] = in_if.target_vel_z;
  assign bdy[0] = in_if.body_x;       assign bdy[1] = in_if.body_y;
  assign bdy[2] = in_if.body_z;
  assign bvl[0] = in_if.body_vel_x;   assign bvl[1] = in_if.body_vel_y;
  assign bvl[2] = in_if.body_vel_z;

  // axis lanes
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    sdfc_lane u_lane (
      .clk           (clk),
      .en            (en),
      .target        (tgt[l]),
      .target_vel    (tvl[l]),
      .body          (bdy[l]),
      .body_vel      (bvl[l]),
      .stiffness     (stiffness_r),
      .damping_gain  (damping_r),
      .max_extension (maxe_r),
      .len_in        (root),
      .clamp_in      (clamp_d_r[SQRT_LAT-1]),
      .sq_out        (sq[l]),
      .force_out     (frc[l]),
      .clamp_out     (lclamp[l])
    );
  end

  // merge: squared length and clamp decision
  always_ff @(posedge clk) begin
    if (en) begin
      s_r      <= sq[0] + sq[1] + sq[2];
      clamp3_r <= (sq[0] + sq[1] + sq[2]) > SUM_W'(me2_r);
      clamp_d_r[0] <= clamp3_r && (maxe_r != '0);
      for (int i = 1; i < SQRT_LAT; i++) begin
        clamp_d_r[i] <= clamp_d_r[i-1];
      end
    end
  end

  sdfc_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .s_in     (s_r),
    .root_out (root)
  );

  // pipeline occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[PIPE_LAT-2:0], in_if.valid};
    end
  end

  assign en          = (cnt_r != 2'd2) || out_if.ready;
  assign in_if.ready = en;

  // output queue
  assign res.force_x     = frc[0];
  assign res.force_y     = frc[1];
  assign res.force_z     = frc[2];
  assign res.was_clamped = lclamp[0];

  assign push = en && v_r[PIPE_LAT-1];
  assign pop  = (cnt_r != 2'd0) && out_if.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign out_if.valid       = cnt_r != 2'd0;
  assign out_if.force_x     = q_r[rptr_r].force_x;
  assign out_if.force_y     = q_r[rptr_r].force_y;
  assign out_if.force_z     = q_r[rptr_r].force_z;
  assign out_if.was_clamped = q_r[rptr_r].was_clamped;

endmodule
